>>> rtl/core/rrts_pkg.sv
// Shared types and codes of the round-robin time-slice scheduler.
// Used by the slot controller, the top level and the port checker.
`default_nettype none

package rrts_pkg;

    // fixed field widths of the two channels
    localparam int unsigned IDX_IN_W  = 4;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned PRI_IN_W  = 8;
    localparam int unsigned TICKS_O_W = 8;

    // slot status codes
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SLEEP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STOP  = 2'd3;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic switched;
        logic none_ready;
    } flags_t;

endpackage

`default_nettype wire

>>> rtl/core/rrts_slot_mem.sv
// Slot table memory: one write port, one registered read port.
// Per-entry valid bits make an unwritten entry read as all zero.
`default_nettype none

module rrts_slot_mem #(
    parameter int unsigned NUM_SLOTS = 16,
    parameter int unsigned DATA_W    = 19
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]            wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
    output logic      [DATA_W-1:0]            rd_data
);

    logic [DATA_W-1:0]    mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/core/rrts_ctrl.sv
// Slot controller: read-modify-write of the slot table and the round-robin scan.
// Depends on rrts_pkg; drives the ports of rrts_slot_mem.
`default_nettype none

module rrts_ctrl #(
    parameter int unsigned NUM_SLOTS  = 16,
    parameter int unsigned TICK_WIDTH = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              in_cmd,
    input  wire logic [rrts_pkg::IDX_IN_W-1:0]     in_slot_index,
    input  wire logic [rrts_pkg::STATUS_W-1:0]     in_slot_status,
    input  wire logic                              in_slot_blocked,
    input  wire logic [rrts_pkg::PRI_IN_W-1:0]     in_slot_priority,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic [$clog2(NUM_SLOTS)-1:0]           res_index,
    output logic [TICK_WIDTH-1:0]                  res_ticks,
    output rrts_pkg::flags_t                       res_flags,
    output logic                                   mem_wr_en,
    output logic [$clog2(NUM_SLOTS)-1:0]           mem_wr_addr,
    output logic [2*TICK_WIDTH+2:0]                mem_wr_data,
    output logic                                   mem_rd_en,
    output logic [$clog2(NUM_SLOTS)-1:0]           mem_rd_addr,
    input  wire logic [2*TICK_WIDTH+2:0]           mem_rd_data
);
    import rrts_pkg::*;

    localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
    localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int unsigned TW    = TICK_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_PUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic                 cmd_reg;
    logic [IDX_IN_W-1:0]  idx_reg;
    logic [STATUS_W-1:0]  st_reg;
    logic                 blk_reg;
    logic [TW-1:0]        pri_reg;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TW-1:0]        keep_reg, keep_next;
    logic [IDX_W-1:0]     res_index_reg, res_index_next;
    logic [TW-1:0]        res_ticks_reg, res_ticks_next;
    flags_t               res_flags_reg, res_flags_next;

    logic [STATUS_W-1:0]  e_st;
    logic                 e_blk;
    logic [TW-1:0]        e_pri;
    logic [TW-1:0]        e_tck;
    logic                 idx_ok;
    logic                 must_leave;
    logic                 need;
    logic [TW-1:0]        new_tck;
    logic                 elig;

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i);
        step_idx = (i == IDX_W'(NUM_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

    assign e_st  = mem_rd_data[2*TW+2 -: 2];
    assign e_blk = mem_rd_data[2*TW];
    assign e_pri = mem_rd_data[2*TW-1 -: TW];
    assign e_tck = mem_rd_data[TW-1:0];

    assign idx_ok     = 32'(idx_reg) < 32'(NUM_SLOTS);
    assign must_leave = (e_st == ST_STOP) || ((e_st == ST_SLEEP) && e_blk);
    assign need       = must_leave || (e_tck == '0);
    assign new_tck    = must_leave ? e_tck : ((e_tck == '0) ? e_pri : e_tck - 1'b1);
    assign elig       = (e_st == ST_RUN) || ((e_st == ST_SLEEP) && !e_blk);

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        scan_next      = scan_reg;
        cnt_next       = cnt_reg;
        keep_next      = keep_reg;
        res_index_next = res_index_reg;
        res_ticks_next = res_ticks_reg;
        res_flags_next = res_flags_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cur_reg;
        mem_wr_data    = {e_st, e_blk, e_pri, new_tck};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = cur_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready  = 1'b1;
                mem_rd_en = in_valid;
                if (in_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                res_index_next = cur_reg;
                res_flags_next = '0;
                if (cmd_reg == CMD_WRITE) begin
                    mem_wr_en   = idx_ok;
                    mem_wr_addr = IDX_W'(idx_reg);
                    mem_wr_data = {st_reg, blk_reg, pri_reg, pri_reg};
                    res_ticks_next = (idx_ok && IDX_W'(idx_reg) == cur_reg) ? pri_reg : e_tck;
                    state_next  = S_PUSH;
                end else begin
                    // write back the counted-down or reloaded slice, or the unchanged slice of a slot that must leave
                    mem_wr_en = 1'b1;
                    res_ticks_next = new_tck;
                    if (need) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = step_idx(cur_reg);
                        scan_next   = step_idx(cur_reg);
                        cnt_next    = CNT_W'(1);
                        keep_next   = new_tck;
                        state_next  = S_SCAN;
                    end else begin
                        state_next  = S_PUSH;
                    end
                end
            end
            S_SCAN: begin
                if (elig) begin
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = scan_reg;
                    mem_wr_data    = {ST_RUN, e_blk, e_pri, e_tck};
                    cur_next       = scan_reg;
                    res_index_next = scan_reg;
                    res_ticks_next = e_tck;
                    res_flags_next = '{switched: 1'b1, none_ready: 1'b0};
                    state_next     = S_PUSH;
                end else if (cnt_reg == CNT_W'(NUM_SLOTS)) begin
                    // wrapped round with nothing eligible: keep the current slot
                    res_index_next = cur_reg;
                    res_ticks_next = keep_reg;
                    res_flags_next = '{switched: 1'b0, none_ready: 1'b1};
                    state_next     = S_PUSH;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = step_idx(scan_reg);
                    scan_next   = step_idx(scan_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            S_PUSH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
        end
        if (in_ready && in_valid) begin
            cmd_reg <= in_cmd;
            idx_reg <= in_slot_index;
            st_reg  <= in_slot_status;
            blk_reg <= in_slot_blocked;
            pri_reg <= TW'(in_slot_priority);
        end
        scan_reg      <= scan_next;
        keep_reg      <= keep_next;
        res_index_reg <= res_index_next;
        res_ticks_reg <= res_ticks_next;
        res_flags_reg <= res_flags_next;
    end

    assign res_index = res_index_reg;
    assign res_ticks = res_ticks_reg;
    assign res_flags = res_flags_reg;

endmodule

`default_nettype wire

>>> rtl/core/round_robin_time_slice_scheduler.sv
// Top level of the round-robin time-slice scheduler: slot table, controller, output register.
// Depends on rrts_pkg, rrts_slot_mem and rrts_ctrl.
//
//   channel   prefix  direction  beat
//   command   s_      in         one slot write or one scheduler tick
//   result    m_      out        one result beat per command beat
//
// A write, or a tick that needs no switch, goes from accept through evaluate and push.
// A tick that needs a switch also scans the slot table, one registered read of the slot
// table a cycle, visiting up to NUM_SLOTS slots before its result is pushed.
// Reset clears the valid bits of the slot table at once; no clearing pass.
// A stalled result sits in the output register while the next beat is taken.
`default_nettype none

module round_robin_time_slice_scheduler #(
    parameter int unsigned NUM_SLOTS  = 16,
    parameter int unsigned TICK_WIDTH = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_cmd,
    input  wire logic [rrts_pkg::IDX_IN_W-1:0]    s_slot_index,
    input  wire logic [rrts_pkg::STATUS_W-1:0]    s_slot_status,
    input  wire logic                             s_slot_blocked,
    input  wire logic [rrts_pkg::PRI_IN_W-1:0]    s_slot_priority,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [rrts_pkg::IDX_IN_W-1:0]         m_current_index,
    output logic                                  m_switched,
    output logic                                  m_none_ready,
    output logic [rrts_pkg::TICKS_O_W-1:0]        m_ticks_left
);
    import rrts_pkg::*;

    localparam int unsigned IDX_W  = $clog2(NUM_SLOTS);
    localparam int unsigned DATA_W = 2 * TICK_WIDTH + 3;

    logic                  res_valid;
    logic                  res_ready;
    logic [IDX_W-1:0]      res_index;
    logic [TICK_WIDTH-1:0] res_ticks;
    flags_t                res_flags;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_W-1:0]     wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_W-1:0]     rd_data;

    logic                  m_valid_reg;
    logic [IDX_IN_W-1:0]   m_index_reg;
    logic                  m_switched_reg;
    logic                  m_none_reg;
    logic [TICKS_O_W-1:0]  m_ticks_reg;

    rrts_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .DATA_W    (DATA_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrts_ctrl #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_cmd           (s_cmd),
        .in_slot_index    (s_slot_index),
        .in_slot_status   (s_slot_status),
        .in_slot_blocked  (s_slot_blocked),
        .in_slot_priority (s_slot_priority),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_index        (res_index),
        .res_ticks        (res_ticks),
        .res_flags        (res_flags),
        .mem_wr_en        (wr_en),
        .mem_wr_addr      (wr_addr),
        .mem_wr_data      (wr_data),
        .mem_rd_en        (rd_en),
        .mem_rd_addr      (rd_addr),
        .mem_rd_data      (rd_data)
    );

    // take a new result whenever the output register is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_index_reg    <= IDX_IN_W'(res_index);
            m_switched_reg <= res_flags.switched;
            m_none_reg     <= res_flags.none_ready;
            m_ticks_reg    <= TICKS_O_W'(res_ticks);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_current_index = m_index_reg;
    assign m_switched      = m_switched_reg;
    assign m_none_ready    = m_none_reg;
    assign m_ticks_left    = m_ticks_reg;

endmodule

`default_nettype wire

>>> rtl/core/rrts_checker.sv
// Port-level checks for the round-robin time-slice scheduler, bound to the top level.
// Depends on rrts_pkg for the field widths.
`default_nettype none

module rrts_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_cmd,
    input wire logic [rrts_pkg::IDX_IN_W-1:0] s_slot_index,
    input wire logic [rrts_pkg::STATUS_W-1:0] s_slot_status,
    input wire logic                          s_slot_blocked,
    input wire logic [rrts_pkg::PRI_IN_W-1:0] s_slot_priority,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [rrts_pkg::IDX_IN_W-1:0] m_current_index,
    input wire logic                          m_switched,
    input wire logic                          m_none_ready,
    input wire logic [rrts_pkg::TICKS_O_W-1:0] m_ticks_left
);
    import rrts_pkg::*;

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one command at a time: busy in the cycle after a beat is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second command taken while busy");

    // a tick either switches or reports nothing ready, never both
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_switched && m_none_ready))
        else $error("switched and none_ready both set");

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_current_index)
            && $stable(m_ticks_left) && $stable(m_switched) && $stable(m_none_ready)))
        else $error("stalled result changed");

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (.*);

`default_nettype wire
